// ----- rtl/core/last_prime_in_sequence_unit_defines.svh -----
// assertion macros shared by the last prime in sequence rtl
`ifndef LAST_PRIME_IN_SEQUENCE_UNIT_DEFINES_SVH
`define LAST_PRIME_IN_SEQUENCE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define LPIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPIS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPIS_ASSERT(lbl, prop, msg)
`define LPIS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/lpis_pkg.sv -----
// shared constants and types for the last prime in sequence unit
package lpis_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int PRIME_BITS  = 15;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [PRIME_BITS-1:0]  prime_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

// ----- rtl/core/last_prime_in_sequence_unit.sv -----
// top level: primality test by trial division and last prime tracking
//
// Each transaction on the input carries one signed value and an is_last flag. A value of
// two or more is tested against the divisor 2 and then the odd divisors d while d*d does
// not exceed the value; every trial runs through a bit-serial remainder unit, and the
// square bound is checked before each trial. At most 1 + floor((sqrt(value)-1)/2)
// divisors are tried, 91 for 16-bit values; values below two skip the trials. The
// block works on one item at a time. On an item with is_last set it presents the most
// recent prime of the sequence, or 0, and starts a new sequence. The result sits in an
// output register, so the next item is taken while it waits; a later result waits in
// S_DONE until the register is free.
`include "last_prime_in_sequence_unit_defines.svh"

module last_prime_in_sequence_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [lpis_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic                                  in_is_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lpis_pkg::PRIME_BITS-1:0]       out_last_prime
);
  import lpis_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TEST = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  value_t      n_r, n_nxt;
  value_t      d_r, d_nxt;
  value_t      sq_r, sq_nxt;
  logic        last_r, last_nxt;
  logic        prime_r, prime_nxt;
  prime_t      latest_r, latest_nxt;
  logic        out_valid_r, out_valid_nxt;
  prime_t      out_prime_r, out_prime_nxt;
  logic        rem_start;
  rem_status_t rem_st;
  prime_t      updated;
  value_t      in_raw;

  assign in_raw  = value_t'(in_value);
  assign updated = prime_r ? PRIME_BITS'(n_r) : latest_r;
  assign in_ready = (state_r == S_IDLE);

  lpis_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (n_r),
    .divisor  (d_r),
    .status   (rem_st)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    last_nxt      = last_r;
    prime_nxt     = prime_r;
    latest_nxt    = latest_r;
    out_prime_nxt = out_prime_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rem_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt    = in_raw;
          last_nxt = in_is_last;
          d_nxt    = value_t'(2);
          sq_nxt   = value_t'(4);
          if (!in_raw[VALUE_WIDTH-1] && in_raw >= value_t'(2)) begin
            state_nxt = S_TEST;
          end else begin
            prime_nxt = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_TEST: begin
        if (sq_r > n_r) begin
          prime_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_st.done) begin
          if (rem_st.zero) begin
            prime_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4, odd divisors only after 2
            if (d_r == value_t'(2)) begin
              d_nxt  = value_t'(3);
              sq_nxt = value_t'(9);
            end else begin
              d_nxt  = d_r + value_t'(2);
              sq_nxt = sq_r + (d_r << 2) + value_t'(4);
            end
            state_nxt = S_TEST;
          end
        end
      end
      S_DONE: begin
        if (!last_r) begin
          latest_nxt = updated;
          state_nxt  = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = updated;
          latest_nxt    = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      latest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      latest_r    <= latest_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    last_r      <= last_nxt;
    prime_r     <= prime_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_last_prime = out_prime_r;

  `LPIS_ASSERT(a_done_only_in_div, rem_st.done |-> state_r == S_DIV, "remainder done outside a trial")
  `LPIS_ASSERT(a_test_starts_div, (state_r == S_TEST && sq_r <= n_r) |=> state_r == S_DIV, "trial not started")
  `LPIS_ASSERT(a_divisor_form, state_r == S_TEST |-> (d_r == value_t'(2) || d_r[0]), "even divisor above two")
  `LPIS_ASSERT(a_result_from_last, $rose(out_valid_r) |-> $past(state_r == S_DONE && last_r), "result without a last item")
  `LPIS_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

// ----- rtl/core/lpis_rem.sv -----
// bit-serial restoring remainder unit, one dividend bit per cycle
`include "last_prime_in_sequence_unit_defines.svh"

module lpis_rem (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  lpis_pkg::value_t      dividend,
  input  lpis_pkg::value_t      divisor,
  output lpis_pkg::rem_status_t status
);
  import lpis_pkg::*;

  logic   busy_r, busy_nxt;
  logic   done_r, done_nxt;
  cnt_t   cnt_r, cnt_nxt;
  value_t sh_r, sh_nxt;
  value_t rem_r, rem_nxt;
  value_t trial;

  // divisor stays below 2^(w-1), so the top remainder bit is always zero
  assign trial = {rem_r[VALUE_WIDTH-2:0], sh_r[VALUE_WIDTH-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      sh_nxt   = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= divisor) ? trial - divisor : trial;
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r - cnt_t'(1);
      if (cnt_r == cnt_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign status.done = done_r;
  assign status.zero = (rem_r == '0);

  `LPIS_ASSERT(a_rem_no_restart, start |-> !busy_r, "remainder unit restarted while busy")
  `LPIS_ASSERT(a_rem_done_after_busy, done_r |-> $past(busy_r), "done without a busy cycle")
  `LPIS_ASSERT(a_rem_cnt_live, busy_r |-> cnt_r != '0, "busy with an empty bit count")

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the last prime in sequence unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpis_pkg::*;

  localparam int ITEM_TARGET    = 450;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 2000;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DIRECTED_ROWS  = 24;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   known;
    prime_t prime;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic signed [VALUE_WIDTH-1:0] in_value = '0;
  logic              in_is_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  prime_t            out_last_prime;

  prime_t    running_prime;
  prime_t    expected_primes[$];
  int        mismatches;
  int        items_sent;
  int        idle_cycles;
  bit        calm;
  bit        hold_request;
  stim_row_t directed_rows [0:DIRECTED_ROWS-1];

  last_prime_in_sequence_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_last_prime (out_last_prime)
  );

  always #1 clk = ~clk;

  function automatic bit is_prime_num(int unsigned n);
    int unsigned div;
    if (n < 2) return 1'b0;
    for (div = 2; div * div <= n; div++) begin
      if (n % div == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // returns 1 when the transaction closes a sequence, answer holds the prime to emit
  function automatic bit track_latest_prime(value_t v, bit last, output prime_t answer);
    if (!v[VALUE_WIDTH-1] && is_prime_num(32'(v))) running_prime = prime_t'(v);
    answer = running_prime;
    if (last) running_prime = '0;
    return last;
  endfunction

  function automatic value_t random_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return value_t'($urandom_range(0, 120));
      4: return value_t'($urandom_range(121, 2000));
      5: return {1'b1, 15'($urandom)};
      6: return value_t'(int'($urandom_range(0, 4)) - 2);
      7: return value_t'($urandom);
      8: return value_t'($urandom_range(32600, 32767));
      default: return value_t'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  task automatic report_mismatch(string what, prime_t got, prime_t want);
    $display("mismatch: %s, got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic offer(value_t v, bit last, bit known, prime_t typed_prime);
    prime_t answer;
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_value   <= v;
    in_is_last <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (track_latest_prime(v, last, answer)) begin
      expected_primes.push_back(known ? typed_prime : answer);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_primes.size() != 0) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin : check_results
    prime_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_primes.size() == 0) begin
        report_mismatch("unexpected transaction", out_last_prime, '0);
      end else begin
        want = expected_primes.pop_front();
        if (out_last_prime !== want) report_mismatch("last_prime", out_last_prime, want);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver side
  initial begin : receiver
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // reset and stimulus
  initial begin : stimulus
    int len;
    bit stalled;
    directed_rows = '{
      '{value_t'(0),      1'b1, 1'b1, prime_t'(0)},
      '{value_t'(2),      1'b1, 1'b1, prime_t'(2)},
      '{value_t'(1),      1'b1, 1'b1, prime_t'(0)},
      '{16'hFFFF,         1'b1, 1'b1, prime_t'(0)},
      '{16'h8000,         1'b1, 1'b1, prime_t'(0)},
      '{value_t'(32749),  1'b1, 1'b1, prime_t'(32749)},
      '{16'h7FFF,         1'b1, 1'b0, prime_t'(0)},
      '{value_t'(32761),  1'b1, 1'b0, prime_t'(0)},
      '{value_t'(3),      1'b0, 1'b0, prime_t'(0)},
      '{value_t'(4),      1'b0, 1'b0, prime_t'(0)},
      '{16'hFFF9,         1'b0, 1'b0, prime_t'(0)},
      '{value_t'(0),      1'b1, 1'b0, prime_t'(0)},
      '{value_t'(5),      1'b0, 1'b0, prime_t'(0)},
      '{value_t'(7),      1'b0, 1'b0, prime_t'(0)},
      '{value_t'(9),      1'b0, 1'b0, prime_t'(0)},
      '{value_t'(1),      1'b1, 1'b0, prime_t'(0)},
      '{value_t'(4),      1'b1, 1'b1, prime_t'(0)},
      '{value_t'(32749),  1'b0, 1'b0, prime_t'(0)},
      '{value_t'(32766),  1'b0, 1'b0, prime_t'(0)},
      '{16'h8001,         1'b1, 1'b0, prime_t'(0)},
      '{value_t'(25),     1'b0, 1'b0, prime_t'(0)},
      '{value_t'(49),     1'b1, 1'b0, prime_t'(0)},
      '{value_t'(8191),   1'b1, 1'b1, prime_t'(8191)},
      '{16'h7FFF,         1'b1, 1'b0, prime_t'(0)}
    };
    running_prime = '0;
    stalled = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].value, directed_rows[i].last, directed_rows[i].known,
            directed_rows[i].prime);
    end
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      if (!stalled && items_sent > 200) begin
        // fill the block while the receiver holds off
        stalled = 1'b1;
        calm = 1'b1;
        hold_request = 1'b1;
        repeat (10) offer(value_t'($urandom_range(0, 60)), 1'b1, 1'b0, '0);
        calm = 1'b0;
        wait_drained();
      end
      if ($urandom_range(0, 20) == 0) wait_drained();
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        offer(random_value(), k == len - 1, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lpis_pkg.sv
rtl/core/lpis_rem.sv
rtl/core/last_prime_in_sequence_unit.sv
tb/sv/testbench.sv
